>>> rtl/core/mse_pkg.sv
// Shared types, opcodes and constants of the MIPS-subset execute unit.
package mse_pkg;

    localparam int unsigned REG_COUNT = 34;
    localparam int unsigned REG_AW    = 6;
    localparam int unsigned MEM_AW    = 15;
    localparam int unsigned MEM_WORDS = 1 << MEM_AW;

    localparam logic [REG_AW-1:0] REG_ZERO = 6'd0;
    localparam logic [REG_AW-1:0] REG_V0   = 6'd2;
    localparam logic [REG_AW-1:0] REG_A0   = 6'd4;
    localparam logic [REG_AW-1:0] REG_SP   = 6'd29;
    localparam logic [REG_AW-1:0] REG_RA   = 6'd31;
    localparam logic [REG_AW-1:0] REG_HI   = 6'd32;
    localparam logic [REG_AW-1:0] REG_LO   = 6'd33;
    localparam logic [31:0]       SP_RESET = 32'd32768;

    localparam logic [31:0] SYS_PRINT_INT = 32'd1;
    localparam logic [31:0] SYS_PRINT_STR = 32'd4;
    localparam logic [31:0] SYS_READ_INT  = 32'd5;
    localparam logic [31:0] SYS_EXIT      = 32'd10;

    localparam logic [1:0] STAT_CONT    = 2'd0;
    localparam logic [1:0] STAT_HALT    = 2'd1;
    localparam logic [1:0] STAT_INVALID = 2'd2;

    localparam logic [1:0] PRINT_NONE = 2'd0;
    localparam logic [1:0] PRINT_INT  = 2'd1;
    localparam logic [1:0] PRINT_STR  = 2'd2;

    typedef enum logic [4:0] {
        OP_SYSCALL = 5'd0,  OP_LI   = 5'd1,  OP_ADD  = 5'd2,  OP_SUB   = 5'd3,
        OP_LW      = 5'd4,  OP_SW   = 5'd5,  OP_J    = 5'd6,  OP_JR    = 5'd7,
        OP_JAL     = 5'd8,  OP_BEQ  = 5'd9,  OP_BGE  = 5'd10, OP_BNE   = 5'd11,
        OP_BGT     = 5'd12, OP_BLE  = 5'd13, OP_BLT  = 5'd14, OP_BEQZ  = 5'd15,
        OP_MOVE    = 5'd16, OP_LA   = 5'd17, OP_ADDI = 5'd18, OP_DIV   = 5'd19,
        OP_MUL     = 5'd20, OP_MFLO = 5'd21, OP_MFHI = 5'd22, OP_ADDU  = 5'd23,
        OP_ADDIU   = 5'd24
    } t_op;

    // Start request to the multiply/divide unit
    typedef struct packed {
        logic start;
        logic is_div;
    } t_mdu_req;

    // Operand count check; syscall takes any count, unknown codes fail
    function automatic logic count_ok(input logic [4:0] op, input logic [1:0] cnt);
        logic ok;
        ok = 1'b0;
        unique case (op) inside
            OP_SYSCALL:                                   ok = 1'b1;
            OP_J, OP_JR, OP_JAL, OP_MFLO, OP_MFHI:        ok = (cnt == 2'd1);
            OP_LI, OP_BEQZ, OP_MOVE, OP_LA, OP_DIV:       ok = (cnt == 2'd2);
            OP_ADD, OP_SUB, OP_LW, OP_SW, OP_BEQ, OP_BGE, OP_BNE, OP_BGT,
            OP_BLE, OP_BLT, OP_ADDI, OP_MUL, OP_ADDU, OP_ADDIU: ok = (cnt == 2'd3);
            default:                                      ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic reg_ok(input logic [31:0] v);
        return (v < 32'(REG_COUNT));
    endfunction

    function automatic logic [REG_AW-1:0] reg_idx(input logic [31:0] v);
        return reg_ok(v) ? v[REG_AW-1:0] : REG_ZERO;
    endfunction

    function automatic logic target_ok(input logic [31:0] v);
        return (v[31:16] == 16'd0);
    endfunction

endpackage

>>> rtl/core/mips_subset_instruction_execute.sv
// Top level: sequencer, execute logic and data memory of the MIPS-subset execute unit.
//
// Usage: one pre-decoded instruction enters as a word on the s_axis channel and one
// result word leaves on the m_axis channel for every instruction.
// s_axis_tready is high only while the block is idle; it drops from acceptance until
// the result word has been taken on m_axis.
// After acceptance the word passes through ST_READ and ST_EXEC to ST_OUT; lw goes
// through ST_LOAD, mul through ST_MDU, and div through ST_MDU and ST_DIV2 first. The
// multiply and divide go through the shared shift-add / restoring unit, one bit per cycle.
// Reset (synchronous, active low) clears the sequencer and the register file
// valid bits: all registers read zero except sp, which reads 32768. The data
// memory is not cleared; no clearing pass is needed.
// When the receiver stalls, the result word holds on m_axis_tdata and the block
// accepts nothing until it is taken.
module mips_subset_instruction_execute (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // action[4:0], operand_count[6:5], operand_a[38:7], operand_b[70:39],
    // operand_c[102:71], current_pc[118:103], read_value[150:119], zero[151]
    input  logic [151:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // next_pc[15:0], redirected[16], status[18:17], print_kind[20:19],
    // print_value[52:21], zero[55:53]
    output logic [55:0]   m_axis_tdata
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_READ = 7'b0000010,
        ST_EXEC = 7'b0000100,
        ST_MDU  = 7'b0001000,
        ST_LOAD = 7'b0010000,
        ST_DIV2 = 7'b0100000,
        ST_OUT  = 7'b1000000
    } t_state;

    t_state      r_state, n_state;
    logic [4:0]  r_action;
    logic [1:0]  r_cnt;
    logic [31:0] r_a, r_b, r_c, r_rv;
    logic [15:0] r_pc;
    logic        r_is_div;

    logic [15:0] r_next;
    logic        r_redir;
    logic [1:0]  r_status, r_kind;
    logic [31:0] r_pval;

    logic [mse_pkg::REG_AW-1:0] w_ra0, w_ra1, w_wa;
    logic [31:0] w_rd0, w_rd1, w_wd;
    logic        w_we;

    mse_pkg::t_mdu_req w_req;
    logic        w_done;
    logic [31:0] w_lo, w_hi;

    logic [31:0] mem [mse_pkg::MEM_WORDS];
    logic [31:0] r_mem_q;
    logic [mse_pkg::MEM_AW-1:0] w_maddr;
    logic [33:0] w_asum;

    // Execute decisions, meaningful in ST_EXEC
    logic        e_bad, e_redir, e_we, e_st, e_ld, e_mdu, e_take;
    logic [15:0] e_next;
    logic [1:0]  e_status, e_kind;
    logic [31:0] e_pval, e_wd;
    logic [mse_pkg::REG_AW-1:0] e_wa;
    logic [16:0] w_pc1;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = {3'b000, r_pval, r_kind, r_status, r_redir, r_next};

    // Capture the instruction word
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_action <= s_axis_tdata[4:0];
            r_cnt    <= s_axis_tdata[6:5];
            r_a      <= s_axis_tdata[38:7];
            r_b      <= s_axis_tdata[70:39];
            r_c      <= s_axis_tdata[102:71];
            r_pc     <= s_axis_tdata[118:103];
            r_rv     <= s_axis_tdata[150:119];
        end
    end

    // Read port selection per opcode
    always_comb begin
        w_ra0 = mse_pkg::REG_ZERO;
        w_ra1 = mse_pkg::REG_ZERO;
        case (r_action) inside
            mse_pkg::OP_SYSCALL: begin
                w_ra0 = mse_pkg::REG_V0;
                w_ra1 = mse_pkg::REG_A0;
            end
            mse_pkg::OP_MOVE, mse_pkg::OP_ADDI, mse_pkg::OP_ADDIU:
                w_ra0 = mse_pkg::reg_idx(r_b);
            mse_pkg::OP_ADD, mse_pkg::OP_SUB, mse_pkg::OP_MUL, mse_pkg::OP_ADDU: begin
                w_ra0 = mse_pkg::reg_idx(r_b);
                w_ra1 = mse_pkg::reg_idx(r_c);
            end
            mse_pkg::OP_DIV, mse_pkg::OP_BEQ, mse_pkg::OP_BGE, mse_pkg::OP_BNE,
            mse_pkg::OP_BGT, mse_pkg::OP_BLE, mse_pkg::OP_BLT: begin
                w_ra0 = mse_pkg::reg_idx(r_a);
                w_ra1 = mse_pkg::reg_idx(r_b);
            end
            mse_pkg::OP_BEQZ, mse_pkg::OP_JR:
                w_ra0 = mse_pkg::reg_idx(r_a);
            mse_pkg::OP_LW, mse_pkg::OP_SW: begin
                w_ra0 = mse_pkg::reg_idx(r_a);
                w_ra1 = mse_pkg::reg_idx(r_c);
            end
            mse_pkg::OP_MFLO: w_ra0 = mse_pkg::REG_LO;
            mse_pkg::OP_MFHI: w_ra0 = mse_pkg::REG_HI;
            default: w_ra0 = mse_pkg::REG_ZERO;
        endcase
    end

    // Load/store address: base register plus offset, both word aligned
    assign w_asum  = {{2{w_rd1[31]}}, w_rd1} + {{2{r_b[31]}}, r_b};
    assign w_maddr = w_asum[mse_pkg::MEM_AW+1:2];
    assign w_pc1   = {1'b0, r_pc} + 17'd1;

    // Execute one instruction
    always_comb begin
        e_bad    = !mse_pkg::count_ok(r_action, r_cnt);
        e_next   = w_pc1[15:0];
        e_redir  = 1'b0;
        e_status = mse_pkg::STAT_CONT;
        e_kind   = mse_pkg::PRINT_NONE;
        e_pval   = 32'd0;
        e_we     = 1'b0;
        e_wa     = mse_pkg::reg_idx(r_a);
        e_wd     = 32'd0;
        e_st     = 1'b0;
        e_ld     = 1'b0;
        e_mdu    = 1'b0;
        e_take   = 1'b0;
        case (r_action) inside
            mse_pkg::OP_SYSCALL: begin
                if (w_rd0 == mse_pkg::SYS_PRINT_INT) begin
                    e_kind = mse_pkg::PRINT_INT;
                    e_pval = w_rd1;
                end else if (w_rd0 == mse_pkg::SYS_PRINT_STR) begin
                    e_kind = mse_pkg::PRINT_STR;
                    e_pval = w_rd1;
                end else if (w_rd0 == mse_pkg::SYS_READ_INT) begin
                    e_we = 1'b1;
                    e_wa = mse_pkg::REG_V0;
                    e_wd = r_rv;
                end else if (w_rd0 == mse_pkg::SYS_EXIT) begin
                    e_status = mse_pkg::STAT_HALT;
                    e_next   = r_pc;
                end
            end
            mse_pkg::OP_LI, mse_pkg::OP_LA: begin
                if (!mse_pkg::reg_ok(r_a)) e_bad = 1'b1;
                e_we = 1'b1;
                e_wd = r_b;
            end
            mse_pkg::OP_MOVE: begin
                if (!mse_pkg::reg_ok(r_a) || !mse_pkg::reg_ok(r_b)) e_bad = 1'b1;
                e_we = 1'b1;
                e_wd = w_rd0;
            end
            mse_pkg::OP_ADD, mse_pkg::OP_SUB, mse_pkg::OP_MUL, mse_pkg::OP_ADDU: begin
                if (!mse_pkg::reg_ok(r_a) || !mse_pkg::reg_ok(r_b) ||
                    !mse_pkg::reg_ok(r_c)) e_bad = 1'b1;
                if (r_action == mse_pkg::OP_MUL) begin
                    e_mdu = 1'b1;
                end else begin
                    e_we = 1'b1;
                    e_wd = (r_action == mse_pkg::OP_SUB) ? (w_rd0 - w_rd1) : (w_rd0 + w_rd1);
                end
            end
            mse_pkg::OP_ADDI, mse_pkg::OP_ADDIU: begin
                if (!mse_pkg::reg_ok(r_a) || !mse_pkg::reg_ok(r_b)) e_bad = 1'b1;
                e_we = 1'b1;
                e_wd = w_rd0 + r_c;
            end
            mse_pkg::OP_DIV: begin
                if (!mse_pkg::reg_ok(r_a) || !mse_pkg::reg_ok(r_b) || w_rd1 == 32'd0)
                    e_bad = 1'b1;
                e_mdu = 1'b1;
            end
            mse_pkg::OP_MFLO, mse_pkg::OP_MFHI: begin
                if (!mse_pkg::reg_ok(r_a)) e_bad = 1'b1;
                e_we = 1'b1;
                e_wd = w_rd0;
            end
            mse_pkg::OP_LW, mse_pkg::OP_SW: begin
                if (!mse_pkg::reg_ok(r_a) || !mse_pkg::reg_ok(r_c) ||
                    w_rd1[1:0] != 2'b00 || r_b[1:0] != 2'b00 || w_asum[33] ||
                    w_asum[33:mse_pkg::MEM_AW+2] != '0) e_bad = 1'b1;
                e_ld = (r_action == mse_pkg::OP_LW);
                e_st = (r_action == mse_pkg::OP_SW);
            end
            mse_pkg::OP_BEQ, mse_pkg::OP_BGE, mse_pkg::OP_BNE,
            mse_pkg::OP_BGT, mse_pkg::OP_BLE, mse_pkg::OP_BLT: begin
                case (r_action)
                    mse_pkg::OP_BEQ: e_take = (w_rd0 == w_rd1);
                    mse_pkg::OP_BGE: e_take = ($signed(w_rd0) >= $signed(w_rd1));
                    mse_pkg::OP_BNE: e_take = (w_rd0 != w_rd1);
                    mse_pkg::OP_BGT: e_take = ($signed(w_rd0) > $signed(w_rd1));
                    mse_pkg::OP_BLE: e_take = ($signed(w_rd0) <= $signed(w_rd1));
                    default:         e_take = ($signed(w_rd0) < $signed(w_rd1));
                endcase
                if (!mse_pkg::reg_ok(r_a) || !mse_pkg::reg_ok(r_b) ||
                    (e_take && !mse_pkg::target_ok(r_c))) e_bad = 1'b1;
                if (e_take) begin
                    e_next  = r_c[15:0];
                    e_redir = 1'b1;
                end
            end
            mse_pkg::OP_BEQZ: begin
                e_take = (w_rd0 == 32'd0);
                if (!mse_pkg::reg_ok(r_a) || (e_take && !mse_pkg::target_ok(r_b)))
                    e_bad = 1'b1;
                if (e_take) begin
                    e_next  = r_b[15:0];
                    e_redir = 1'b1;
                end
            end
            mse_pkg::OP_J, mse_pkg::OP_JAL: begin
                if (!mse_pkg::target_ok(r_a)) e_bad = 1'b1;
                e_next  = r_a[15:0];
                e_redir = 1'b1;
                e_we    = (r_action == mse_pkg::OP_JAL);
                e_wa    = mse_pkg::REG_RA;
                e_wd    = {15'd0, w_pc1};
            end
            mse_pkg::OP_JR: begin
                if (!mse_pkg::reg_ok(r_a) || !mse_pkg::target_ok(w_rd0)) e_bad = 1'b1;
                e_next  = w_rd0[15:0];
                e_redir = 1'b1;
            end
            default: e_bad = 1'b1;
        endcase
        // An invalid instruction leaves all state alone
        if (e_bad) begin
            e_next   = r_pc;
            e_redir  = 1'b0;
            e_status = mse_pkg::STAT_INVALID;
            e_kind   = mse_pkg::PRINT_NONE;
            e_pval   = 32'd0;
            e_we     = 1'b0;
            e_st     = 1'b0;
            e_ld     = 1'b0;
            e_mdu    = 1'b0;
        end
    end

    // Start the shared multiply/divide unit
    assign w_req.start  = (r_state == ST_EXEC) && e_mdu;
    assign w_req.is_div = (r_action == mse_pkg::OP_DIV);

    // Register file write port
    always_comb begin
        w_we = 1'b0;
        w_wa = mse_pkg::reg_idx(r_a);
        w_wd = e_wd;
        unique case (r_state)
            ST_EXEC: begin
                w_we = e_we;
                w_wa = e_wa;
            end
            ST_MDU: begin
                w_we = w_done;
                w_wa = r_is_div ? mse_pkg::REG_LO : mse_pkg::reg_idx(r_a);
                w_wd = w_lo;
            end
            ST_DIV2: begin
                w_we = 1'b1;
                w_wa = mse_pkg::REG_HI;
                w_wd = w_hi;
            end
            ST_LOAD: begin
                w_we = 1'b1;
                w_wd = r_mem_q;
            end
            default: w_we = 1'b0;
        endcase
    end

    mse_regfile u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ra0   (w_ra0),
        .i_ra1   (w_ra1),
        .o_rd0   (w_rd0),
        .o_rd1   (w_rd1),
        .i_we    (w_we),
        .i_wa    (w_wa),
        .i_wd    (w_wd)
    );

    mse_mdu u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_x     (w_rd0),
        .i_y     (w_rd1),
        .o_done  (w_done),
        .o_lo    (w_lo),
        .o_hi    (w_hi)
    );

    // Data memory: store in execute, registered read for loads
    always_ff @(posedge i_clk) begin
        if (r_state == ST_EXEC && e_st) begin
            mem[w_maddr] <= w_rd0;
        end
        r_mem_q <= mem[w_maddr];
    end

    // Hold the result word
    always_ff @(posedge i_clk) begin
        if (r_state == ST_EXEC) begin
            r_next   <= e_next;
            r_redir  <= e_redir;
            r_status <= e_status;
            r_kind   <= e_kind;
            r_pval   <= e_pval;
            r_is_div <= w_req.is_div;
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (s_axis_tvalid) n_state = ST_READ;
            ST_READ: n_state = ST_EXEC;
            ST_EXEC: begin
                if (e_mdu)      n_state = ST_MDU;
                else if (e_ld)  n_state = ST_LOAD;
                else            n_state = ST_OUT;
            end
            ST_MDU:  if (w_done) n_state = r_is_div ? ST_DIV2 : ST_OUT;
            ST_DIV2: n_state = ST_OUT;
            ST_LOAD: n_state = ST_OUT;
            ST_OUT:  if (m_axis_tready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef ASSERT_OFF
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("input and output open together");
    a_accept_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_state == ST_READ)
        else $error("accepted word not read");
    a_mdu_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |=> r_state == ST_MDU) else $error("mdu start without wait");
    a_bad_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC && e_bad) |-> !w_we && !w_req.start)
        else $error("invalid instruction changed state");
`endif

endmodule

>>> rtl/core/mse_regfile.sv
// Register file of 34 words with two registered read ports and one write port.
module mse_regfile (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [mse_pkg::REG_AW-1:0]    i_ra0,
    input  logic [mse_pkg::REG_AW-1:0]    i_ra1,
    output logic [31:0]                   o_rd0,
    output logic [31:0]                   o_rd1,
    input  logic                          i_we,
    input  logic [mse_pkg::REG_AW-1:0]    i_wa,
    input  logic [31:0]                   i_wd
);

    logic [31:0]                     mem [mse_pkg::REG_COUNT];
    logic [mse_pkg::REG_COUNT-1:0]   r_valid;

    // Value of an entry that was never written
    function automatic logic [31:0] reset_val(input logic [mse_pkg::REG_AW-1:0] a);
        return (a == mse_pkg::REG_SP) ? mse_pkg::SP_RESET : 32'd0;
    endfunction

    // Write port; register zero stays hardwired
    always_ff @(posedge i_clk) begin
        if (i_we && i_wa != mse_pkg::REG_ZERO) begin
            mem[i_wa] <= i_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we && i_wa != mse_pkg::REG_ZERO) begin
            r_valid[i_wa] <= 1'b1;
        end
    end

    // Registered reads
    always_ff @(posedge i_clk) begin
        o_rd0 <= r_valid[i_ra0] ? mem[i_ra0] : reset_val(i_ra0);
        o_rd1 <= r_valid[i_ra1] ? mem[i_ra1] : reset_val(i_ra1);
    end

endmodule

>>> rtl/core/mse_mdu.sv
// Iterative multiply/divide unit: one shared adder, one bit per cycle.
module mse_mdu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mse_pkg::t_mdu_req i_req,
    input  logic [31:0]       i_x,
    input  logic [31:0]       i_y,
    output logic              o_done,
    output logic [31:0]       o_lo,
    output logic [31:0]       o_hi
);

    logic        r_busy, r_div, r_neg_q, r_neg_r;
    logic [4:0]  r_cnt;
    logic [32:0] r_acc;
    logic [31:0] r_q, r_y;
    logic [32:0] w_t;
    logic [33:0] w_sum;
    logic [31:0] w_ax, w_ay;

    assign w_ax = i_x[31] ? (32'd0 - i_x) : i_x;
    assign w_ay = i_y[31] ? (32'd0 - i_y) : i_y;

    // Shared adder: partial remainder minus divisor, or accumulate multiplicand
    assign w_t   = {r_acc[31:0], r_q[31]};
    assign w_sum = r_div ? ({1'b0, w_t} - {2'b00, r_y})
                         : ({1'b0, r_acc} + {2'b00, r_y});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    // Load operands, then step one bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_div   <= i_req.is_div;
            r_acc   <= '0;
            r_neg_q <= i_x[31] ^ i_y[31];
            r_neg_r <= i_x[31];
            r_q     <= i_req.is_div ? w_ax : i_y;
            r_y     <= i_req.is_div ? w_ay : i_x;
        end else if (r_busy) begin
            if (r_div) begin
                r_acc <= w_sum[33] ? w_t : w_sum[32:0];
                r_q   <= {r_q[30:0], ~w_sum[33]};
            end else begin
                if (r_q[0]) begin
                    r_acc <= {1'b0, w_sum[31:0]};
                end
                r_q <= {1'b0, r_q[31:1]};
                r_y <= {r_y[30:0], 1'b0};
            end
        end
    end

    assign o_lo = r_div ? (r_neg_q ? (32'd0 - r_q) : r_q) : r_acc[31:0];
    assign o_hi = r_neg_r ? (32'd0 - r_acc[31:0]) : r_acc[31:0];

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy) else $error("mdu started while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy) && !r_busy) else $error("done without busy");
    a_step_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == 5'd31) |=> o_done) else $error("mdu did not finish");
`endif

endmodule

>>> tb/mips_subset_instruction_execute_tb.sv
// Testbench for the MIPS-subset execute unit: directed and random instruction streams.
`timescale 1ns / 1ps

module mips_subset_instruction_execute_tb;

    // One pre-decoded instruction, packed as on s_axis_tdata (action in the lowest bits)
    typedef struct packed {
        logic [31:0] rv;
        logic [15:0] pc;
        logic [31:0] c;
        logic [31:0] b;
        logic [31:0] a;
        logic [1:0]  cnt;
        logic [4:0]  op;
    } t_instr;

    // One result, packed as on m_axis_tdata
    typedef struct packed {
        logic [31:0] pval;
        logic [1:0]  kind;
        logic [1:0]  status;
        logic        redir;
        logic [15:0] next;
    } t_result;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [151:0]  s_axis_tdata = '0;  // action, count, a, b, c, pc, read_value, zero
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [55:0]   m_axis_tdata;       // next_pc, redirected, status, print_kind, print_value

    // Predictor state: register file and the data words written so far
    logic [31:0] regs [mse_pkg::REG_COUNT];
    logic [31:0] mem_words [int];
    int          written_addrs [$];

    t_result pending_results [$];
    int      n_errors = 0;
    int      n_sent = 0;
    int      n_checked = 0;
    int      n_invalid = 0;
    int      n_halt = 0;
    int      n_print = 0;
    int      n_redir = 0;
    int      burst_left = 0;

    mips_subset_instruction_execute DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(5_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [31:0] rd_reg(input longint r);
        if (r <= 0 || r >= mse_pkg::REG_COUNT) return 32'd0;
        return regs[r];
    endfunction

    function automatic void wr_reg(input longint r, input logic [31:0] v);
        if (r > 0 && r < mse_pkg::REG_COUNT) regs[r] = v;
    endfunction

    function automatic logic reg_in_range(input longint r);
        return r >= 0 && r < mse_pkg::REG_COUNT;
    endfunction

    function automatic logic pc_in_range(input longint t);
        return t >= 0 && t <= 65535;
    endfunction

    function automatic logic count_matches(input logic [4:0] op, input logic [1:0] cnt);
        case (op)
            mse_pkg::OP_SYSCALL: return 1'b1;
            mse_pkg::OP_J, mse_pkg::OP_JR, mse_pkg::OP_JAL, mse_pkg::OP_MFLO,
            mse_pkg::OP_MFHI: return cnt == 2'd1;
            mse_pkg::OP_LI, mse_pkg::OP_BEQZ, mse_pkg::OP_MOVE, mse_pkg::OP_LA,
            mse_pkg::OP_DIV: return cnt == 2'd2;
            mse_pkg::OP_ADD, mse_pkg::OP_SUB, mse_pkg::OP_LW, mse_pkg::OP_SW,
            mse_pkg::OP_BEQ, mse_pkg::OP_BGE, mse_pkg::OP_BNE, mse_pkg::OP_BGT,
            mse_pkg::OP_BLE, mse_pkg::OP_BLT, mse_pkg::OP_ADDI, mse_pkg::OP_MUL,
            mse_pkg::OP_ADDU, mse_pkg::OP_ADDIU: return cnt == 2'd3;
            default: return 1'b0;
        endcase
    endfunction

    // Execute one instruction against the predictor state and return its result word
    function automatic t_result execute_instr(input t_instr w);
        longint  a, b, c, x, y, base, addr, t;
        logic    bad, take;
        logic [31:0] v0, r;
        t_result res;
        a = longint'($signed(w.a));
        b = longint'($signed(w.b));
        c = longint'($signed(w.c));
        res = '0;
        res.next = w.pc + 16'd1;
        bad = !count_matches(w.op, w.cnt);
        if (!bad) begin
            case (w.op)
                mse_pkg::OP_SYSCALL: begin
                    v0 = rd_reg(mse_pkg::REG_V0);
                    if (v0 == mse_pkg::SYS_PRINT_INT) begin
                        res.kind = mse_pkg::PRINT_INT;
                        res.pval = rd_reg(mse_pkg::REG_A0);
                    end else if (v0 == mse_pkg::SYS_PRINT_STR) begin
                        res.kind = mse_pkg::PRINT_STR;
                        res.pval = rd_reg(mse_pkg::REG_A0);
                    end else if (v0 == mse_pkg::SYS_READ_INT) begin
                        wr_reg(mse_pkg::REG_V0, w.rv);
                    end else if (v0 == mse_pkg::SYS_EXIT) begin
                        res.status = mse_pkg::STAT_HALT;
                        res.next = w.pc;
                    end
                end
                mse_pkg::OP_LI, mse_pkg::OP_LA: begin
                    if (!reg_in_range(a)) bad = 1'b1;
                    else wr_reg(a, w.b);
                end
                mse_pkg::OP_MOVE: begin
                    if (!reg_in_range(a) || !reg_in_range(b)) bad = 1'b1;
                    else wr_reg(a, rd_reg(b));
                end
                mse_pkg::OP_ADD, mse_pkg::OP_SUB, mse_pkg::OP_MUL, mse_pkg::OP_ADDU: begin
                    if (!reg_in_range(a) || !reg_in_range(b) || !reg_in_range(c)) begin
                        bad = 1'b1;
                    end else begin
                        if (w.op == mse_pkg::OP_SUB) r = rd_reg(b) - rd_reg(c);
                        else if (w.op == mse_pkg::OP_MUL) r = rd_reg(b) * rd_reg(c);
                        else r = rd_reg(b) + rd_reg(c);
                        wr_reg(a, r);
                    end
                end
                mse_pkg::OP_ADDI, mse_pkg::OP_ADDIU: begin
                    if (!reg_in_range(a) || !reg_in_range(b)) bad = 1'b1;
                    else wr_reg(a, rd_reg(b) + w.c);
                end
                mse_pkg::OP_DIV: begin
                    if (!reg_in_range(a) || !reg_in_range(b)) begin
                        bad = 1'b1;
                    end else begin
                        x = longint'($signed(rd_reg(a)));
                        y = longint'($signed(rd_reg(b)));
                        if (y == 0) begin
                            bad = 1'b1;
                        end else begin
                            wr_reg(mse_pkg::REG_LO, 32'(x / y));
                            wr_reg(mse_pkg::REG_HI, 32'(x % y));
                        end
                    end
                end
                mse_pkg::OP_MFLO, mse_pkg::OP_MFHI: begin
                    if (!reg_in_range(a)) bad = 1'b1;
                    else wr_reg(a, rd_reg(w.op == mse_pkg::OP_MFLO ? mse_pkg::REG_LO
                                                                     : mse_pkg::REG_HI));
                end
                mse_pkg::OP_LW, mse_pkg::OP_SW: begin
                    if (!reg_in_range(a) || !reg_in_range(c)) begin
                        bad = 1'b1;
                    end else begin
                        base = longint'($signed(rd_reg(c)));
                        addr = (base + b) / 4;
                        if (base[1:0] != 2'd0 || w.b[1:0] != 2'd0) bad = 1'b1;
                        else if (addr < 0 || addr >= mse_pkg::MEM_WORDS) bad = 1'b1;
                        else if (w.op == mse_pkg::OP_LW) wr_reg(a, mem_words[int'(addr)]);
                        else begin
                            if (!mem_words.exists(int'(addr)))
                                written_addrs.insert(written_addrs.size(), int'(addr));
                            mem_words[int'(addr)] = rd_reg(a);
                        end
                    end
                end
                mse_pkg::OP_BEQ, mse_pkg::OP_BGE, mse_pkg::OP_BNE,
                mse_pkg::OP_BGT, mse_pkg::OP_BLE, mse_pkg::OP_BLT: begin
                    if (!reg_in_range(a) || !reg_in_range(b)) begin
                        bad = 1'b1;
                    end else begin
                        x = longint'($signed(rd_reg(a)));
                        y = longint'($signed(rd_reg(b)));
                        case (w.op)
                            mse_pkg::OP_BEQ: take = x == y;
                            mse_pkg::OP_BGE: take = x >= y;
                            mse_pkg::OP_BNE: take = x != y;
                            mse_pkg::OP_BGT: take = x > y;
                            mse_pkg::OP_BLE: take = x <= y;
                            default:         take = x < y;
                        endcase
                        if (take) begin
                            if (!pc_in_range(c)) bad = 1'b1;
                            else begin
                                res.next = 16'(c);
                                res.redir = 1'b1;
                            end
                        end
                    end
                end
                mse_pkg::OP_BEQZ: begin
                    if (!reg_in_range(a)) bad = 1'b1;
                    else if (rd_reg(a) == 32'd0) begin
                        if (!pc_in_range(b)) bad = 1'b1;
                        else begin
                            res.next = 16'(b);
                            res.redir = 1'b1;
                        end
                    end
                end
                mse_pkg::OP_J, mse_pkg::OP_JAL: begin
                    if (!pc_in_range(a)) begin
                        bad = 1'b1;
                    end else begin
                        // jal links pc + 1 without the 16-bit wrap
                        if (w.op == mse_pkg::OP_JAL)
                            wr_reg(mse_pkg::REG_RA, 32'(w.pc) + 32'd1);
                        res.next = 16'(a);
                        res.redir = 1'b1;
                    end
                end
                mse_pkg::OP_JR: begin
                    if (!reg_in_range(a)) bad = 1'b1;
                    else begin
                        t = longint'($signed(rd_reg(a)));
                        if (!pc_in_range(t)) bad = 1'b1;
                        else begin
                            res.next = 16'(t);
                            res.redir = 1'b1;
                        end
                    end
                end
                default: bad = 1'b1;
            endcase
        end
        // Invalid instruction: hold pc, no state change (all writes above are skipped)
        if (bad) begin
            res = '0;
            res.next = w.pc;
            res.status = mse_pkg::STAT_INVALID;
        end
        return res;
    endfunction

    // Steer a well-formed load onto a word that was already written, or misalign it if none was
    function automatic t_instr fix_load(input t_instr w);
        longint base, addr;
        int     k;
        if (w.op != mse_pkg::OP_LW || w.cnt != 2'd3 || w.a >= mse_pkg::REG_COUNT ||
            w.c >= mse_pkg::REG_COUNT)
            return w;
        base = longint'($signed(rd_reg(w.c)));
        if (base[1:0] != 2'd0 || w.b[1:0] != 2'd0) return w;
        addr = (base + longint'($signed(w.b))) / 4;
        if (addr < 0 || addr >= mse_pkg::MEM_WORDS || mem_words.exists(int'(addr))) return w;
        if (written_addrs.size() == 0) begin
            w.b[0] = 1'b1;
        end else begin
            k = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
            w.b = 32'(longint'(k) * 4 - base);
        end
        return w;
    endfunction

    function automatic t_instr mk(input logic [4:0] op, input logic [1:0] cnt,
                                  input logic [31:0] a, input logic [31:0] b,
                                  input logic [31:0] c);
        t_instr w;
        w.op = op;
        w.cnt = cnt;
        w.a = a;
        w.b = b;
        w.c = c;
        w.pc = 16'($urandom);
        w.rv = $urandom;
        return w;
    endfunction

    // Send one word in bursts with random gaps; predict it at the handshake
    task automatic send_word(input t_instr w);
        t_result want;
        w = fix_load(w);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, w};
        do @(posedge i_clk); while (!s_axis_tready);
        want = execute_instr(w);
        pending_results.insert(pending_results.size(), want);
        burst_left--;
        n_sent++;
        @(negedge i_clk);
    endtask

    // Hold the sender until every predicted word has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        n_errors++;
        $display("[%0t] mismatch on %s: got 0x%08h, want 0x%08h", $realtime, field, got, want);
    endtask

    // Check each result word against the oldest prediction
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[52:0]);
            if (m_axis_tdata[55:53] != 3'd0)
                report_mismatch("pad", 32'(m_axis_tdata[55:53]), 32'd0);
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word", m_axis_tdata[31:0], 32'd0);
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (got.next != want.next)
                    report_mismatch("next_pc", 32'(got.next), 32'(want.next));
                if (got.redir != want.redir)
                    report_mismatch("redirected", 32'(got.redir), 32'(want.redir));
                if (got.status != want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                if (got.kind != want.kind)
                    report_mismatch("print_kind", 32'(got.kind), 32'(want.kind));
                if (got.pval != want.pval)
                    report_mismatch("print_value", got.pval, want.pval);
                if (want.status == mse_pkg::STAT_INVALID) n_invalid++;
                if (want.status == mse_pkg::STAT_HALT) n_halt++;
                if (want.kind != mse_pkg::PRINT_NONE) n_print++;
                if (want.redir) n_redir++;
            end
        end
    end

    // Receiver stall pattern: always ready, random, or a rotating bit mask
    initial begin
        int          mode, left;
        logic [15:0] mask;
        left = 0;
        mode = 0;
        mask = 16'hA5C3;
        forever begin
            @(negedge i_clk);
            if (left == 0) begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(20, 150);
                mask = 16'($urandom);
            end
            left--;
            case (mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: begin
                    m_axis_tready <= mask[0];
                    mask = {mask[0], mask[15:1]};
                end
            endcase
        end
    end

    task automatic test_arith();
        send_word(mk(mse_pkg::OP_LI, 2, 8, 32'h7FFF_FFFF, 0));
        send_word(mk(mse_pkg::OP_LA, 2, 9, 32'h8000_0000, 0));
        send_word(mk(mse_pkg::OP_ADD, 3, 10, 8, 8));
        send_word(mk(mse_pkg::OP_SUB, 3, 11, 9, 8));
        send_word(mk(mse_pkg::OP_ADDU, 3, 0, 8, 8));          // write to $zero is dropped
        send_word(mk(mse_pkg::OP_ADDIU, 3, 12, 8, 1));
        send_word(mk(mse_pkg::OP_ADDI, 3, 13, 0, 32'hFFFF_FFFF));
        send_word(mk(mse_pkg::OP_MOVE, 2, 19, 8, 0));
    endtask

    task automatic test_mul_div();
        send_word(mk(mse_pkg::OP_MUL, 3, 14, 8, 9));
        send_word(mk(mse_pkg::OP_DIV, 2, 9, 13, 0));          // most negative by -1 wraps
        send_word(mk(mse_pkg::OP_MFHI, 1, 16, 0, 0));
        send_word(mk(mse_pkg::OP_MFLO, 1, 17, 0, 0));
        send_word(mk(mse_pkg::OP_DIV, 2, 8, 0, 0));           // divide by zero
    endtask

    task automatic test_memory();
        send_word(mk(mse_pkg::OP_SW, 3, 8, 32'hFFFF_FFFC, mse_pkg::REG_SP));
        send_word(mk(mse_pkg::OP_LW, 3, 18, 32'hFFFF_FFFC, mse_pkg::REG_SP));
        send_word(mk(mse_pkg::OP_SW, 3, 8, 2, 0));            // misaligned offset
        send_word(mk(mse_pkg::OP_SW, 3, 8, 32'd131072, 0));   // past the last word
    endtask

    task automatic test_branches();
        send_word(mk(mse_pkg::OP_BEQ, 3, 8, 19, 65535));
        send_word(mk(mse_pkg::OP_BLT, 3, 8, 9, 70000));       // untaken, target not checked
        send_word(mk(mse_pkg::OP_BGT, 3, 8, 9, 70000));       // taken, target out of range
        send_word(mk(mse_pkg::OP_BGE, 3, 9, 8, 3));
        send_word(mk(mse_pkg::OP_BNE, 3, 8, 9, 4));
        send_word(mk(mse_pkg::OP_BLE, 3, 9, 8, 0));
        send_word(mk(mse_pkg::OP_BEQZ, 2, 0, 5, 0));
    endtask

    task automatic test_jumps();
        t_instr w;
        w = mk(mse_pkg::OP_JAL, 1, 100, 0, 0);
        w.pc = 16'hFFFF;                             // link value does not wrap
        send_word(w);
        send_word(mk(mse_pkg::OP_JR, 1, mse_pkg::REG_RA, 0, 0));
        send_word(mk(mse_pkg::OP_J, 1, 0, 0, 0));
    endtask

    task automatic test_syscall();
        send_word(mk(mse_pkg::OP_LI, 2, mse_pkg::REG_A0, 32'h8000_0001, 0));
        send_word(mk(mse_pkg::OP_LI, 2, mse_pkg::REG_V0, mse_pkg::SYS_PRINT_INT, 0));
        send_word(mk(mse_pkg::OP_SYSCALL, 0, 0, 0, 0));
        send_word(mk(mse_pkg::OP_LI, 2, mse_pkg::REG_V0, mse_pkg::SYS_PRINT_STR, 0));
        send_word(mk(mse_pkg::OP_SYSCALL, 3, 0, 0, 0));
        send_word(mk(mse_pkg::OP_LI, 2, mse_pkg::REG_V0, mse_pkg::SYS_READ_INT, 0));
        send_word(mk(mse_pkg::OP_SYSCALL, 1, 0, 0, 0));
        send_word(mk(mse_pkg::OP_LI, 2, mse_pkg::REG_V0, mse_pkg::SYS_EXIT, 0));
        send_word(mk(mse_pkg::OP_SYSCALL, 2, 0, 0, 0));
        send_word(mk(mse_pkg::OP_LI, 2, mse_pkg::REG_V0, 7, 0));
        send_word(mk(mse_pkg::OP_SYSCALL, 0, 0, 0, 0));
    endtask

    task automatic test_malformed();
        send_word(mk(mse_pkg::OP_ADD, 2, 1, 2, 3));           // wrong operand count
        send_word(mk(5'd31, 3, 1, 2, 3));                      // unknown opcode
        send_word(mk(mse_pkg::OP_LI, 2, 34, 1, 0));           // register out of range
        send_word(mk(mse_pkg::OP_MOVE, 2, 1, 32'hFFFF_FFFF, 0));
    endtask

    function automatic logic [31:0] pick_reg();
        case ($urandom_range(0, 19))
            0: return $urandom;
            1: return $urandom_range(34, 63);
            default: return $urandom_range(0, 33);
        endcase
    endfunction

    function automatic logic [31:0] pick_imm();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'(int'($urandom_range(0, 4000)) - 2000);
            default: return 32'(int'($urandom_range(0, 40)) - 20);
        endcase
    endfunction

    // Mostly well-formed instructions with random content, some noise
    function automatic t_instr rand_instr();
        t_instr w;
        logic [4:0] op;
        if ($urandom_range(0, 9) == 0) begin
            w = t_instr'(151'({$urandom, $urandom, $urandom, $urandom, $urandom}));
            return w;
        end
        op = 5'($urandom_range(0, 24));
        w = mk(op, 3, pick_reg(), pick_reg(), pick_reg());
        case (op)
            mse_pkg::OP_J, mse_pkg::OP_JR, mse_pkg::OP_JAL, mse_pkg::OP_MFLO,
            mse_pkg::OP_MFHI: w.cnt = 1;
            mse_pkg::OP_LI, mse_pkg::OP_BEQZ, mse_pkg::OP_MOVE, mse_pkg::OP_LA,
            mse_pkg::OP_DIV: w.cnt = 2;
            mse_pkg::OP_SYSCALL: w.cnt = 2'($urandom);
            default: ;
        endcase
        case (op)
            mse_pkg::OP_LI, mse_pkg::OP_LA: begin
                w.b = pick_imm();
                if ($urandom_range(0, 3) == 0) begin
                    w.a = mse_pkg::REG_V0;
                    case ($urandom_range(0, 3))
                        0: w.b = mse_pkg::SYS_PRINT_INT;
                        1: w.b = mse_pkg::SYS_PRINT_STR;
                        2: w.b = mse_pkg::SYS_READ_INT;
                        default: w.b = mse_pkg::SYS_EXIT;
                    endcase
                end
            end
            mse_pkg::OP_ADDI, mse_pkg::OP_ADDIU: w.c = pick_imm();
            mse_pkg::OP_LW, mse_pkg::OP_SW: begin
                if ($urandom_range(0, 1) == 0) begin
                    w.c = mse_pkg::REG_ZERO;
                    w.b = 32'($urandom_range(0, 63) * 4);
                end else if ($urandom_range(0, 3) != 0) begin
                    w.c = mse_pkg::REG_SP;
                    w.b = 32'((int'($urandom_range(0, 127)) - 64) * 4);
                end else begin
                    w.b = pick_imm();
                end
            end
            mse_pkg::OP_BEQ, mse_pkg::OP_BGE, mse_pkg::OP_BNE,
            mse_pkg::OP_BGT, mse_pkg::OP_BLE, mse_pkg::OP_BLT:
                w.c = ($urandom_range(0, 7) == 0) ? pick_imm() : $urandom_range(0, 65535);
            mse_pkg::OP_BEQZ:
                w.b = ($urandom_range(0, 7) == 0) ? pick_imm() : $urandom_range(0, 65535);
            mse_pkg::OP_J, mse_pkg::OP_JAL:
                w.a = ($urandom_range(0, 7) == 0) ? pick_imm() : $urandom_range(0, 65535);
            default: ;
        endcase
        // Occasionally break the operand count
        if ($urandom_range(0, 19) == 0) w.cnt = 2'($urandom);
        return w;
    endfunction

    task automatic test_random(input int n_items);
        for (int i = 0; i < n_items; i++) begin
            send_word(rand_instr());
            if (i == n_items / 2) drain_results();
        end
    endtask

    initial begin
        for (int i = 0; i < mse_pkg::REG_COUNT; i++) regs[i] = 32'd0;
        regs[mse_pkg::REG_SP] = mse_pkg::SP_RESET;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_arith();
        test_mul_div();
        test_memory();
        test_branches();
        test_jumps();
        test_syscall();
        test_malformed();
        drain_results();
        test_random(1600);

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("Ran %0d instructions, checked %0d results: %0d invalid, %0d halts,",
                 n_sent, n_checked, n_invalid, n_halt);
        $display("%0d print requests, %0d redirects, %0d memory words touched.",
                 n_print, n_redir, written_addrs.size());
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
